@@ src/lpr_pkg.sv @@
package lpr_pkg;

    // Fixed field widths and default parameters of the pair reduction interface.
    localparam int NORM_W         = 56;
    localparam int IDX_W          = 6;
    localparam int DEF_MAX_DIM    = 64;
    localparam int DEF_COORD_BITS = 24;

    localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

    typedef enum logic [1:0] {
        OUTC_NONE    = 2'd0,
        OUTC_B_REPL  = 2'd1,
        OUTC_A_REPL  = 2'd2,
        OUTC_COLLIDE = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FLUSH,
        ST_ABS,
        ST_SUM,
        ST_CMP,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // input transfer taken this cycle
        logic abs_en;     // capture magnitude and sign of the inner product
        logic sum_en;     // form the unclamped candidate norm
        logic cmp_en;     // clamp and compare the candidate norm
        logic single_ld;  // load a single no-change or collision result
        logic rd_first;   // start emission at coordinate zero
        logic emit_ld;    // load one replaced coordinate into the output register
    } lpr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic replace;    // the candidate replaces a or b
        logic out_free;   // the output register can take a result this cycle
        logic idx_last;   // the coordinate being emitted is the final one
    } lpr_sts_t;

endpackage

@@ src/lpr_ram.sv @@
module lpr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/lpr_ctrl.sv @@
module lpr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    input  lpr_pkg::lpr_sts_t sts,
    output logic              s_tready,
    output lpr_pkg::lpr_cmd_t cmd
);

    import lpr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (s_tlast)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            // The last product enters the accumulator here.
            ST_FLUSH:
            begin
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.abs_en = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp_en = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (sts.replace)
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = ST_EMIT;
                end
                else if (sts.out_free)
                begin
                    cmd.single_ld = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_ld = 1'b1;
                    if (sts.idx_last)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

@@ src/lpr_datapath.sv @@
module lpr_datapath #(
    parameter int MAX_DIM    = 64,
    parameter int COORD_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lpr_pkg::lpr_cmd_t                   cmd,
    input  logic signed [COORD_BITS-1:0]        a_coord,
    input  logic signed [COORD_BITS-1:0]        b_coord,
    input  logic [lpr_pkg::NORM_W-1:0]          a_norm,
    input  logic [lpr_pkg::NORM_W-1:0]          b_norm,
    input  logic                                same_entry,
    input  logic                                in_last,
    input  logic                                m_tready,
    output lpr_pkg::lpr_sts_t                   sts,
    output logic                                m_valid,
    output lpr_pkg::outcome_t                   m_outcome,
    output logic [lpr_pkg::IDX_W-1:0]           m_index,
    output logic signed [COORD_BITS:0]          m_coord,
    output logic [lpr_pkg::NORM_W-1:0]          m_norm,
    output logic                                m_shortest,
    output logic                                m_last
);

    import lpr_pkg::*;

    localparam int ADDR_W = $clog2(MAX_DIM);
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int PROD_W = 2 * COORD_BITS;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
    // One bit above the largest magnitude so that the sum of two full norms stays positive.
    localparam int SUM_W  = ((ACC_W + 2 > NORM_W + 2) ? ACC_W + 2 : NORM_W + 2) + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIM);

    // Control state.
    logic [CNT_W-1:0]        pair_count_reg, pair_count_next;
    logic                    prod_valid_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [NORM_W-1:0]       shortest_reg;
    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic                    m_valid_reg, m_valid_next;

    // Payload.
    logic [CNT_W-1:0]         dim_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [NORM_W-1:0]        an_reg, bn_reg;
    logic                     same_reg;
    logic [ACC_W-1:0]         abs_reg;
    logic                     ip_pos_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [NORM_W-1:0]        norm_reg;
    logic                     zero_reg, repl_b_reg, repl_a_reg, shorter_reg;
    outcome_t                 outcome_reg;
    logic [IDX_W-1:0]         index_reg;
    logic signed [COORD_BITS:0] coord_reg;
    logic [NORM_W-1:0]        norm_out_reg;
    logic                     short_out_reg, last_out_reg;

    logic                    has_room;
    logic                    wr_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic [COORD_BITS-1:0]   a_rd, b_rd;
    logic [NORM_W-1:0]       norm_clamp;
    logic signed [COORD_BITS:0] x_ext, y_ext, coord_new;

    assign has_room = (pair_count_reg < MAX_CNT);
    assign wr_en    = cmd.load && has_room;

    always_comb
    begin
        if (cmd.rd_first)
        begin
            rd_addr = '0;
        end
        else if (cmd.emit_ld)
        begin
            rd_addr = idx_reg + ADDR_W'(1);
        end
        else
        begin
            rd_addr = idx_reg;
        end
    end

    lpr_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (MAX_DIM)
    ) u_a_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pair_count_reg[ADDR_W-1:0]),
        .wr_data (a_coord),
        .rd_addr (rd_addr),
        .rd_data (a_rd)
    );

    lpr_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (MAX_DIM)
    ) u_b_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pair_count_reg[ADDR_W-1:0]),
        .wr_data (b_coord),
        .rd_addr (rd_addr),
        .rd_data (b_rd)
    );

    always_comb
    begin
        pair_count_next = pair_count_reg;
        if (cmd.load)
        begin
            if (in_last)
            begin
                pair_count_next = '0;
            end
            else if (has_room)
            begin
                pair_count_next = pair_count_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.abs_en)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.rd_first)
        begin
            idx_next = '0;
        end
        else if (cmd.emit_ld)
        begin
            idx_next = idx_reg + ADDR_W'(1);
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.single_ld || cmd.emit_ld)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // Clamp the candidate norm to the unsigned norm range.
    always_comb
    begin
        if (sum_reg[SUM_W-1])
        begin
            norm_clamp = '0;
        end
        else if (|sum_reg[SUM_W-2:NORM_W])
        begin
            norm_clamp = NORM_MAX;
        end
        else
        begin
            norm_clamp = sum_reg[NORM_W-1:0];
        end
    end

    // The sign opposes the inner product: subtract when it was positive.
    assign x_ext     = repl_b_reg ? $signed({b_rd[COORD_BITS-1], b_rd})
                                  : $signed({a_rd[COORD_BITS-1], a_rd});
    assign y_ext     = repl_b_reg ? $signed({a_rd[COORD_BITS-1], a_rd})
                                  : $signed({b_rd[COORD_BITS-1], b_rd});
    assign coord_new = ip_pos_reg ? (x_ext - y_ext) : (x_ext + y_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_count_reg <= '0;
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
            shortest_reg   <= NORM_MAX;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            pair_count_reg <= pair_count_next;
            prod_valid_reg <= wr_en;
            acc_reg        <= acc_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
            if (cmd.rd_first && shorter_reg)
            begin
                shortest_reg <= norm_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prod_reg <= a_coord * b_coord;
        end
        if (cmd.load && in_last)
        begin
            dim_reg  <= has_room ? pair_count_reg + CNT_W'(1) : pair_count_reg;
            an_reg   <= a_norm;
            bn_reg   <= b_norm;
            same_reg <= same_entry;
        end
        if (cmd.abs_en)
        begin
            abs_reg    <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
            ip_pos_reg <= !acc_reg[ACC_W-1] && (acc_reg != '0);
        end
        if (cmd.sum_en)
        begin
            sum_reg <= $signed(SUM_W'(an_reg) + SUM_W'(bn_reg) - (SUM_W'(abs_reg) << 1));
        end
        if (cmd.cmp_en)
        begin
            norm_reg    <= norm_clamp;
            zero_reg    <= (norm_clamp == '0);
            repl_b_reg  <= (norm_clamp != '0) && (norm_clamp < bn_reg);
            repl_a_reg  <= (norm_clamp != '0) && !(norm_clamp < bn_reg) &&
                           (norm_clamp < an_reg);
            shorter_reg <= (norm_clamp < shortest_reg);
        end
        if (cmd.single_ld)
        begin
            outcome_reg   <= (zero_reg && !same_reg) ? OUTC_COLLIDE : OUTC_NONE;
            index_reg     <= '0;
            coord_reg     <= '0;
            norm_out_reg  <= '0;
            short_out_reg <= 1'b0;
            last_out_reg  <= 1'b1;
        end
        else if (cmd.emit_ld)
        begin
            outcome_reg   <= repl_b_reg ? OUTC_B_REPL : OUTC_A_REPL;
            index_reg     <= IDX_W'(idx_reg);
            coord_reg     <= coord_new;
            norm_out_reg  <= norm_reg;
            short_out_reg <= shorter_reg;
            last_out_reg  <= sts.idx_last;
        end
    end

    assign sts.replace  = repl_b_reg || repl_a_reg;
    assign sts.out_free = !m_valid_reg || m_tready;
    assign sts.idx_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == dim_reg);

    assign m_valid    = m_valid_reg;
    assign m_outcome  = outcome_reg;
    assign m_index    = index_reg;
    assign m_coord    = coord_reg;
    assign m_norm     = norm_out_reg;
    assign m_shortest = short_out_reg;
    assign m_last     = last_out_reg;

endmodule

@@ src/lattice_pair_reduction.sv @@
// Channel  Dir  Payload
// s_axis   in   tdata a_coord/b_coord/a_norm/b_norm, tuser same_entry, tlast last pair
// m_axis   out  tdata coord_index/new_coord/new_norm/new_shortest, tuser outcome, tlast final
//
// The input side accepts coordinate pairs back to back. After the last pair the block
// takes the decision in steps (accumulator flush, magnitude, candidate sum, clamp and
// compare, decide), then emits one result per cycle while the output takes them, from
// the single read port of the coordinate memories: N results for a replacement of an
// N-dimensional pair and a single result otherwise. Reset clears the pair count and the
// inner product and sets the shortest norm to all ones; the coordinate memories are not
// cleared. A stalled result holds the output register and pauses emission or the decision.
module lattice_pair_reduction #(
    parameter int MAX_DIM    = lpr_pkg::DEF_MAX_DIM,
    parameter int COORD_BITS = lpr_pkg::DEF_COORD_BITS,
    localparam int IN_W  = ((2 * COORD_BITS + 2 * lpr_pkg::NORM_W + 7) / 8) * 8,
    localparam int OUT_W = ((lpr_pkg::IDX_W + COORD_BITS + 2 + lpr_pkg::NORM_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // a_coord, b_coord, a_norm, b_norm from bit 0 up
    input  logic             s_tuser,   // same_entry
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // coord_index, new_coord, new_norm, new_shortest
    output logic [1:0]       m_tuser,   // outcome
    output logic             m_tlast
);

    import lpr_pkg::*;

    lpr_cmd_t cmd;
    lpr_sts_t sts;

    outcome_t                   outcome;
    logic [IDX_W-1:0]           coord_index;
    logic signed [COORD_BITS:0] new_coord;
    logic [NORM_W-1:0]          new_norm;
    logic                       new_shortest;

    // The controller sequences loading, the decision steps and emission.
    lpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // The datapath holds the coordinate memories, the inner product accumulator,
    // the norm arithmetic and the output register.
    lpr_datapath #(
        .MAX_DIM    (MAX_DIM),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .a_coord    ($signed(s_tdata[COORD_BITS-1:0])),
        .b_coord    ($signed(s_tdata[2*COORD_BITS-1:COORD_BITS])),
        .a_norm     (s_tdata[2*COORD_BITS+NORM_W-1:2*COORD_BITS]),
        .b_norm     (s_tdata[2*COORD_BITS+2*NORM_W-1:2*COORD_BITS+NORM_W]),
        .same_entry (s_tuser),
        .in_last    (s_tlast),
        .m_tready   (m_tready),
        .sts        (sts),
        .m_valid    (m_tvalid),
        .m_outcome  (outcome),
        .m_index    (coord_index),
        .m_coord    (new_coord),
        .m_norm     (new_norm),
        .m_shortest (new_shortest),
        .m_last     (m_tlast)
    );

    assign m_tdata = OUT_W'({new_shortest, new_norm, new_coord, coord_index});
    assign m_tuser = outcome;

    // The last pair of a run closes the input until the decision and any emission are done.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken directly after the last pair");

    // A collision is always a single, final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == OUTC_COLLIDE)) |-> m_tlast)
        else $error("collision result not marked final");

    // Results without a replaced vector carry no coordinate or norm.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ((m_tuser == OUTC_NONE) || (m_tuser == OUTC_COLLIDE)))
        |-> ((m_tdata == '0) && m_tlast))
        else $error("single result carries data");

    // Emission never overlaps with taking new pairs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_ld || cmd.rd_first) |-> !s_tready)
        else $error("input open during emission");

endmodule
